// ----- rtl/core/pldi_pkg.sv -----
// Package for the piecewise-linear depth interpolator.
// Holds the field widths, the table entry type and the result and command codes.
// It depends on nothing else.
package pldi_pkg;

  localparam int POS_W   = 16;  // sensor and channel position
  localparam int DEP_W   = 16;  // signed Q8.8 depth
  localparam int SIDX_W  = 4;   // sensor_index field
  localparam int CFG_W   = 5;   // sensor_count register
  localparam int FRAC_W  = 16;  // Q0.16 fraction
  localparam int QUOT_W  = FRAC_W + 1;  // fraction reaches 1.0
  localparam int EDGE_W  = 2;

  // input tdata layout, lowest bits first
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [EDGE_W-1:0] EDGE_INTERP = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_FIRST  = 2'd1;
  localparam logic [EDGE_W-1:0] EDGE_LAST   = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [DEP_W-1:0] dep;
  } entry_t;

  // divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/piecewise_linear_depth_interp.sv -----
// Piecewise-linear depth interpolator, top level.
// Instantiates pldi_table and pldi_div; types and codes from pldi_pkg.
//
// Usage:
//   Input stream (in_*): in_tuser carries the command, 0 = load one table
//   entry, 1 = query one channel position. A load beat writes sensor position
//   and depth into the addressed entry and gives no result; an index at or
//   above MAX_SENSORS is dropped. A query beat gives exactly one result beat.
//   Output stream (out_*): out_tdata is the depth (signed Q8.8), out_tuser
//   carries the edge code (interpolated, held first, held last) and a flag
//   set when a sensor depth that was used is negative.
//   Config: cfg_wr_en writes sensor_count (0 acts as 1, above MAX_SENSORS
//   acts as MAX_SENSORS). Write it only while the block is idle.
//   Sequence: a load is written on accept. A query walks the table one entry per
//   cycle through the single memory read port, then classifies, then for the
//   interpolated case runs the 16-step serial divider, one multiply and one
//   add; a held depth skips those three. One item is worked on at a time.
//   Stall: the result sits in an output register; the block keeps accepting
//   loads and the next query while it waits, and holds a finished query in
//   its last step until the register frees up.
//   Reset: sensor_count returns to 1, both streams go idle. Table contents
//   are undefined until loaded.
module piecewise_linear_depth_interp
  import pldi_pkg::*;
#(
  parameter int MAX_SENSORS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,    // sensor_count
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [3:0] sensor_index, [19:4] sensor_position, [35:20] sensor_depth,
  // [51:36] channel_position, [55:52] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,       // [0] cmd
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,      // [15:0] channel_depth
  output logic [2:0]            out_tuser       // [1:0] edge_res, [2] depth_negative
);

  localparam int IDX_W = $clog2(MAX_SENSORS);
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // unpack the input beat
  logic [SIDX_W-1:0]       f_idx;
  logic [POS_W-1:0]        f_spos;
  logic signed [DEP_W-1:0] f_sdep;
  logic [POS_W-1:0]        f_cpos;

  assign f_idx  = in_tdata[3:0];
  assign f_spos = in_tdata[19:4];
  assign f_sdep = in_tdata[35:20];
  assign f_cpos = in_tdata[51:36];

  logic [2:0]              state_r, state_nxt;
  logic [CFG_W-1:0]        count_r;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        n_use;
  logic [CNT_W-1:0]        n_m1;
  logic [CNT_W-1:0]        k_r;
  logic [CNT_W-1:0]        dk_r;
  logic                    dv_r;
  logic                    take_nxt_r;
  logic [POS_W-1:0]        c_r;
  logic [POS_W-1:0]        first_pos_r, last_pos_r, a_r, b_r;
  logic signed [DEP_W-1:0] first_dep_r, last_dep_r, d0_r, d1_r;
  logic [QUOT_W-1:0]       t_r;
  logic signed [DEP_W+QUOT_W+1:0] prod_r;
  logic signed [DEP_W-1:0] res_r;
  logic [EDGE_W-1:0]       edge_r;
  logic                    neg_r;
  logic                    out_tvalid_r;
  logic signed [DEP_W-1:0] out_depth_r;
  logic [EDGE_W-1:0]       out_edge_r;
  logic                    out_neg_r;

  logic                    in_fire;
  logic                    is_query;
  logic                    out_free;
  logic                    scan_last;
  logic                    issue;
  logic                    hold_first, hold_last;

  logic                    tbl_wr_en;
  logic [IDX_W-1:0]        tbl_rd_addr;
  entry_t                  tbl_wr_data;
  entry_t                  tbl_rd_data;

  logic                    div_start;
  div_stat_t               div_stat;
  logic [QUOT_W-1:0]       div_quot;

  logic signed [DEP_W:0]   diff;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign is_query  = (in_tuser == CMD_QUERY);
  assign out_free  = !out_tvalid_r || out_tready;

  // clamp sensor_count to the usable range
  always_comb begin
    if (count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(count_r) > 32'(MAX_SENSORS)) begin
      n_use = CNT_W'(MAX_SENSORS);
    end else begin
      n_use = CNT_W'(count_r);
    end
  end

  assign n_m1      = n_r - 1'b1;
  assign scan_last = dv_r && (dk_r == n_m1);
  assign issue     = (state_r == S_SCAN) && (k_r < n_r);

  // table ports: loads write on accept, reads walk the entries in order
  assign tbl_wr_en       = in_fire && !is_query && (32'(f_idx) < 32'(MAX_SENSORS));
  assign tbl_wr_data.pos = f_spos;
  assign tbl_wr_data.dep = f_sdep;
  assign tbl_rd_addr     = issue ? IDX_W'(k_r) : '0;

  pldi_table #(
    .DEPTH (MAX_SENSORS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (IDX_W'(f_idx)),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign hold_first = (c_r <= first_pos_r);
  assign hold_last  = (c_r >= last_pos_r);
  assign div_start  = (state_r == S_CLASS) && !hold_first && !hold_last;

  pldi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (c_r - a_r),
    .den   (b_r - a_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && is_query) state_nxt = S_SCAN;
      S_SCAN:  if (scan_last) state_nxt = S_CLASS;
      S_CLASS: state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:   if (div_stat.done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= CFG_W'(1);
      dv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      // entry 0 is read at the accept edge, later entries while scanning
      dv_r <= (in_fire && is_query) || issue;
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign diff = {d1_r[DEP_W-1], d1_r} - {d0_r[DEP_W-1], d0_r};

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire && is_query) begin
      c_r        <= f_cpos;
      n_r        <= n_use;
      k_r        <= CNT_W'(1);
      dk_r       <= '0;
      take_nxt_r <= 1'b0;
    end else begin
      if (issue) begin
        k_r <= k_r + 1'b1;
      end
      dk_r <= k_r;
    end

    if (dv_r && state_r == S_SCAN) begin
      if (dk_r == '0) begin
        first_pos_r <= tbl_rd_data.pos;
        first_dep_r <= tbl_rd_data.dep;
      end
      if (scan_last) begin
        last_pos_r <= tbl_rd_data.pos;
        last_dep_r <= tbl_rd_data.dep;
      end
      // the entry after a hit is the upper end of the segment
      if (take_nxt_r) begin
        b_r  <= tbl_rd_data.pos;
        d1_r <= tbl_rd_data.dep;
      end
      take_nxt_r <= !scan_last && (c_r > tbl_rd_data.pos);
      if (!scan_last && (c_r > tbl_rd_data.pos)) begin
        a_r  <= tbl_rd_data.pos;
        d0_r <= tbl_rd_data.dep;
      end
    end

    case (state_r)
      S_CLASS: begin
        if (hold_first) begin
          res_r  <= first_dep_r;
          edge_r <= EDGE_FIRST;
          neg_r  <= first_dep_r[DEP_W-1];
        end else if (hold_last) begin
          res_r  <= last_dep_r;
          edge_r <= EDGE_LAST;
          neg_r  <= last_dep_r[DEP_W-1];
        end else begin
          edge_r <= EDGE_INTERP;
          neg_r  <= d0_r[DEP_W-1] || d1_r[DEP_W-1];
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          t_r <= div_quot;
        end
      end
      S_MUL: begin
        prod_r <= diff * $signed({1'b0, t_r});
      end
      S_ADD: begin
        // result stays between both depths, so the low bits are exact
        res_r <= d0_r + $signed(prod_r[FRAC_W+DEP_W-1:FRAC_W]);
      end
      S_DONE: begin
        if (out_free) begin
          out_depth_r <= res_r;
          out_edge_r  <= edge_r;
          out_neg_r   <= neg_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_depth_r;
  assign out_tuser  = {out_neg_r, out_edge_r};

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_query |=> state_r == S_SCAN)
    else $error("query accepted but scan not started");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !is_query |=> state_r == S_IDLE)
    else $error("load left the idle state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r && state_r == S_SCAN |-> dk_r < n_r)
    else $error("scan read beyond sensor count");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> t_r != '0 && t_r <= QUOT_W'(1 << FRAC_W))
    else $error("interpolation fraction out of range");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

endmodule

// ----- rtl/core/pldi_table.sv -----
// Sensor table memory: one write port, one registered read port.
// Uses entry_t from pldi_pkg.
module pldi_table
  import pldi_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/pldi_div.sv -----
// Restoring bit-serial divider for the Q0.16 interpolation fraction.
// Computes floor(num * 2^16 / den) for 0 < num <= den; uses pldi_pkg.
module pldi_div
  import pldi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [POS_W-1:0]  num,
  input  logic [POS_W-1:0]  den,
  output div_stat_t         stat,
  output logic [QUOT_W-1:0] quot
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [POS_W:0]    rem_r;
  logic [POS_W-1:0]  den_r;
  logic [QUOT_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [POS_W:0]    rem_sh;
  logic              take;
  logic              first_bit;

  // remainder stays below den, so its top bit is clear before the shift
  assign rem_sh    = {rem_r[POS_W-1:0], 1'b0};
  assign take      = rem_sh >= {1'b0, den_r};
  assign first_bit = num >= den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      q_r   <= QUOT_W'(first_bit);
      rem_r <= first_bit ? {1'b0, num - den} : {1'b0, num};
    end else if (busy_r) begin
      q_r   <= {q_r[QUOT_W-2:0], take};
      rem_r <= take ? rem_sh - {1'b0, den_r} : rem_sh;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

// ----- sim/tb_piecewise_linear_depth_interp.sv -----
// Testbench for piecewise_linear_depth_interp: streams table loads and depth queries,
// predicts every result beat and compares it field by field. Depends on pldi_pkg and the RTL.
`timescale 1ns / 1ps

module tb_piecewise_linear_depth_interp;
  import pldi_pkg::*;

  localparam int MAX_SENSORS   = 16;
  localparam int NUM_PHASES    = 16;   // random phases, each with its own sensor_count
  localparam int PHASE_ITEMS   = 108;  // beats per random phase after the table reload
  localparam int SETTLE_CYCLES = 64;   // drain time after the last result
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off

  // one input beat, split into its fields
  typedef struct packed {
    logic              cmd;
    logic [SIDX_W-1:0] idx;
    logic [POS_W-1:0]  spos;
    logic [DEP_W-1:0]  sdep;
    logic [POS_W-1:0]  cpos;
  } cable_beat_t;

  // one result beat
  typedef struct packed {
    logic [DEP_W-1:0]  depth;
    logic [EDGE_W-1:0] edge_code;
    logic              neg;
  } depth_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // [3:0] idx, [19:4] spos, [35:20] sdep, [51:36] cpos
  logic                  in_tuser = 1'b0;   // [0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] channel_depth
  logic [2:0]            out_tuser;         // [1:0] edge_res, [2] depth_negative

  piecewise_linear_depth_interp #(.MAX_SENSORS(MAX_SENSORS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the sensor table, updated in beat order at
  // the edge where each beat is accepted, and of sensor_count, set by set_count.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]        pos_tab [MAX_SENSORS];
  logic signed [DEP_W-1:0] dep_tab [MAX_SENSORS];
  logic [CFG_W-1:0]        sensor_count_m = CFG_W'(1);

  depth_result_t depth_expect [$];   // results owed by accepted queries, oldest first
  cable_beat_t   pending_beats [$];  // beats waiting for the driver
  cable_beat_t   cur_beat;           // beat currently offered on the input

  int beats_queued = 0;
  int beats_accepted = 0;
  int err_count = 0;
  int n_loads = 0, n_interp = 0, n_first = 0, n_last = 0, n_settings = 0;

  // generator's view of the table, used only to aim queries at useful positions
  logic [POS_W-1:0] plan_pos [MAX_SENSORS];
  int               plan_n = 1;

  // sender and receiver behavior, switched per phase
  logic     sender_idle = 1'b1;
  rx_mode_t rx_mode = RX_COIN;
  logic     hold_req = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // Interpolated or held depth for one channel position against the current table.
  function automatic depth_result_t interp_depth(input logic [POS_W-1:0] chan);
    depth_result_t r;
    int     n, j, k;
    longint a, b, frac, d0, d1, acc;
    n = (sensor_count_m == 0) ? 1 :
        (sensor_count_m > MAX_SENSORS) ? MAX_SENSORS : int'(sensor_count_m);
    if (chan <= pos_tab[0]) begin
      r.depth     = dep_tab[0];
      r.edge_code = EDGE_FIRST;
      r.neg       = dep_tab[0][DEP_W-1];
    end else if (chan >= pos_tab[n-1]) begin
      r.depth     = dep_tab[n-1];
      r.edge_code = EDGE_LAST;
      r.neg       = dep_tab[n-1][DEP_W-1];
    end else begin
      // last sensor strictly below the channel, even in an unsorted table
      j = 0;
      for (k = 0; k + 1 < n; k++)
        if (chan > pos_tab[k]) j = k;
      a = pos_tab[j];
      b = pos_tab[j+1];
      frac = (b > a) ? ((longint'(chan) - a) << FRAC_W) / (b - a) : 65536;
      if (frac > 65536) frac = 65536;
      d0  = dep_tab[j];
      d1  = dep_tab[j+1];
      acc = (d0 * (65536 - frac) + d1 * frac) >>> FRAC_W;  // floor toward minus infinity
      r.depth     = acc[DEP_W-1:0];
      r.edge_code = EDGE_INTERP;
      r.neg       = (d0 < 0) || (d1 < 0);
    end
    return r;
  endfunction

  // Apply one accepted beat to the predictor.
  task automatic absorb_beat(input cable_beat_t b);
    depth_result_t r;
    if (b.cmd == CMD_LOAD) begin
      pos_tab[b.idx] = b.spos;
      dep_tab[b.idx] = b.sdep;
      n_loads++;
    end else begin
      r = interp_depth(b.cpos);
      depth_expect.push_back(r);
      case (r.edge_code)
        EDGE_INTERP: n_interp++;
        EDGE_FIRST:  n_first++;
        default:     n_last++;
      endcase
    end
    beats_accepted++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer beats from the pending queue in bursts of random length, with
  // random gaps while sender_idle is set; hold each beat until the block takes it.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_beat(cur_beat);
      end
      // advance only when no beat is held on the bus
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 || pending_beats.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          cur_beat = pending_beats.pop_front();
          in_tdata  <= {{(IN_DATA_W-52){1'b0}}, cur_beat.cpos, cur_beat.sdep,
                        cur_beat.spos, cur_beat.idx};
          in_tuser  <= cur_beat.cmd;
          in_tvalid <= 1'b1;
          if (burst_left == 0) begin
            // end of burst: pick the next burst and the gap before it
            burst_left = $urandom_range(1, 24);
            gap_left   = sender_idle ? $urandom_range(0, 9) : 0;
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check every accepted result beat against the oldest expectation,
  // and drive out_tready on its own stall pattern. A toggle of hold_req starts a
  // long hold-off that this block counts down itself.
  // ---------------------------------------------------------------------------
  logic    hold_ack = 1'b0;
  int      hold_left = 0;
  int      rx_cycle = 0;
  depth_result_t got_exp;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (depth_expect.size() == 0) begin
          report_mismatch($sformatf("result beat with no query outstanding, depth %h",
                                    out_tdata));
        end else begin
          got_exp = depth_expect.pop_front();
          if (out_tdata !== got_exp.depth)
            report_mismatch($sformatf("channel_depth %h, predicted %h",
                                      out_tdata, got_exp.depth));
          if (out_tuser[1:0] !== got_exp.edge_code)
            report_mismatch($sformatf("edge_res %0d, predicted %0d",
                                      out_tuser[1:0], got_exp.edge_code));
          if (out_tuser[2] !== got_exp.neg)
            report_mismatch($sformatf("depth_negative %b, predicted %b",
                                      out_tuser[2], got_exp.neg));
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack   <= hold_req;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:  out_tready <= 1'b1;
          RX_COIN:  out_tready <= ($urandom_range(0, 3) != 0);
          default:  out_tready <= ((rx_cycle % 5) != 3) && ((rx_cycle % 11) > 2);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [DEP_W-1:0] rand_depth();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return DEP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_load(input logic [SIDX_W-1:0] idx, input logic [POS_W-1:0] pos,
                           input logic [DEP_W-1:0] dep);
    cable_beat_t b;
    b.cmd  = CMD_LOAD;
    b.idx  = idx;
    b.spos = pos;
    b.sdep = dep;
    b.cpos = POS_W'($urandom_range(0, 65535));  // ignored by a load
    pending_beats.push_back(b);
    plan_pos[idx] = pos;
    beats_queued++;
  endtask

  task automatic push_query(input logic [POS_W-1:0] cpos);
    cable_beat_t b;
    b.cmd  = CMD_QUERY;
    b.idx  = SIDX_W'($urandom_range(0, 15));      // load fields carry junk on a query
    b.spos = POS_W'($urandom_range(0, 65535));
    b.sdep = DEP_W'($urandom_range(0, 65535));
    b.cpos = cpos;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // Hold until every queued beat is taken and every result has come back, then
  // let the block drain. Returns on a rising edge.
  task automatic wait_idle();
    while (beats_accepted != beats_queued || depth_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write sensor_count; call only while idle, on a rising edge.
  task automatic set_count(input logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    sensor_count_m  = v;
    plan_n          = (v == 0) ? 1 : (v > MAX_SENSORS) ? MAX_SENSORS : int'(v);
    n_settings++;
  endtask

  initial begin
    int               ph, k, i, r, step_max, cur;
    int               lo, hi;
    logic [POS_W-1:0] cpos;
    logic [CFG_W-1:0] cnt;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: single sensor at reset count, hold on both sides
    push_load(SIDX_W'(0), 16'd1000, 16'h8000);
    push_query(16'd0);
    push_query(16'd1000);     // channel on the only sensor holds it as first
    push_query(16'd1001);
    push_query(16'hFFFF);
    wait_idle();

    // count of zero behaves as one
    set_count(CFG_W'(0));
    push_query(16'd999);
    push_query(16'd5000);

    // full table spanning the whole position range, depths at the extremes and at +1.0 and -1.0
    for (i = 0; i < MAX_SENSORS; i++) begin
      case (i % 4)
        0:       push_load(SIDX_W'(i), POS_W'(i * 4369), 16'h7FFF);
        1:       push_load(SIDX_W'(i), POS_W'(i * 4369), 16'h8000);
        2:       push_load(SIDX_W'(i), POS_W'(i * 4369), 16'h0100);
        default: push_load(SIDX_W'(i), POS_W'(i * 4369), 16'hFF00);
      endcase
    end
    wait_idle();
    set_count(CFG_W'(16));
    push_query(16'd0);        // at the first sensor
    push_query(16'hFFFF);     // at the last sensor
    push_query(16'd4369);     // exactly on an inner sensor: fraction reaches one
    push_query(16'd2184);     // midway between the two depth extremes
    push_query(16'd30000);
    push_query(16'hFFFE);

    // --- random phases: new count, table reload, then mostly queries
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // sender pauses here until every expected result has come back
      wait_idle();
      case (ph)
        0:       cnt = CFG_W'(2);
        1:       cnt = CFG_W'(16);
        2:       cnt = CFG_W'(17);    // above the table size: clamps to 16
        3:       cnt = CFG_W'(31);
        4:       cnt = CFG_W'(0);
        5:       cnt = CFG_W'(1);
        6:       cnt = CFG_W'(3);
        default: cnt = CFG_W'($urandom_range(0, 31));
      endcase
      set_count(cnt);
      sender_idle <= (ph % 3 != 0);
      case (ph % 4)
        0:       rx_mode <= RX_OPEN;
        1:       rx_mode <= RX_COIN;
        default: rx_mode <= RX_PATTERN;
      endcase
      // long receiver hold-off while the sender keeps offering: fills the block
      if (ph == 2 || ph == 9) hold_req <= ~hold_req;

      // reload every entry: ascending most of the time, scattered now and then
      case (ph % 3)
        0:       step_max = 3;
        1:       step_max = 300;
        default: step_max = 4095;
      endcase
      cur = $urandom_range(0, 65535 - 15 * step_max);
      for (i = 0; i < MAX_SENSORS; i++) begin
        if (ph % 5 == 4) begin
          push_load(SIDX_W'(i), POS_W'($urandom_range(0, 65535)), rand_depth());
        end else begin
          push_load(SIDX_W'(i), POS_W'(cur), rand_depth());
          cur += $urandom_range(0, step_max);
        end
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // stray load mid-stream, may break the ordering of the table
          push_load(SIDX_W'($urandom_range(0, 15)), POS_W'($urandom_range(0, 65535)),
                    rand_depth());
        end else begin
          lo = int'(plan_pos[0]);
          hi = int'(plan_pos[plan_n-1]);
          r  = $urandom_range(0, 99);
          if (r < 45) begin
            cpos = POS_W'($urandom_range(lo, hi));
          end else if (r < 65) begin
            i    = $urandom_range(0, plan_n - 1);
            cpos = POS_W'(plan_pos[i] + $urandom_range(0, 2) - 1);
          end else if (r < 85) begin
            cpos = POS_W'($urandom_range(0, 65535));
          end else begin
            case ($urandom_range(0, 3))
              0:       cpos = 16'h0000;
              1:       cpos = 16'hFFFF;
              2:       cpos = POS_W'(lo);
              default: cpos = POS_W'(hi);
            endcase
          end
          push_query(cpos);
        end
      end
    end

    wait_idle();
    $display("covered %0d loads and %0d queries: %0d interpolated, %0d held first, %0d held last",
             n_loads, n_interp + n_first + n_last, n_interp, n_first, n_last);
    $display("across %0d sensor_count settings, %0d mismatches", n_settings, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Generous limit, several times the slowest correct run.
  initial begin
    #6_000_000;
    $display("timeout with %0d results outstanding", depth_expect.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ----- piecewise_linear_depth_interp.f -----
rtl/core/pldi_pkg.sv
rtl/core/pldi_table.sv
rtl/core/pldi_div.sv
rtl/core/piecewise_linear_depth_interp.sv
sim/tb_piecewise_linear_depth_interp.sv
